>>> src/tlvhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvhp_pkg
// Types, codes and helpers shared by the TLV header parser modules.
// ----------------------------------------------------------------------------
package tlvhp_pkg;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_TAG     = 3'd1,
		PH_LEN_HI  = 3'd2,
		PH_LEN_MID = 3'd3,
		PH_LEN_LO  = 3'd4,
		PH_VALUE   = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	localparam logic [2:0] ST_PARSING  = 3'd0;
	localparam logic [2:0] ST_COMPLETE = 3'd1;
	localparam logic [2:0] ST_UNKNOWN  = 3'd2;
	localparam logic [2:0] ST_OVERRUN  = 3'd3;
	localparam logic [2:0] ST_SHORT    = 3'd4;
	localparam logic [2:0] ST_ENDED    = 3'd5;

	localparam logic [7:0] TAG_END = 8'h00;
	localparam logic [7:0] TAG_K   = 8'h6B;
	localparam logic [7:0] TAG_S   = 8'h73;
	localparam logic [7:0] TAG_D   = 8'h64;
	localparam logic [7:0] TAG_I   = 8'h69;
	localparam logic [7:0] TAG_M   = 8'h6D;
	localparam logic [7:0] TAG_N   = 8'h6E;
	localparam logic [7:0] TAG_T   = 8'h74;
	localparam logic [7:0] TAG_A   = 8'h61;

	localparam logic [2:0] INT_BYTES = 3'd4;

	typedef struct packed {
		logic [31:0] pos;
		phase_t      phase;
		logic [7:0]  tag;
		logic [23:0] len;
		logic [31:0] acc;
		logic [2:0]  iseen;
		logic [2:0]  fstat;
	} parse_st_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  value_byte;
		logic        value_valid;
		logic [7:0]  field_tag;
		logic        field_end;
		logic [31:0] iteration_count;
		logic        iteration_valid;
	} parse_res_t;

	function automatic logic known_tag(input logic [7:0] t);
		return t inside {TAG_K, TAG_S, TAG_D, TAG_I, TAG_M, TAG_N, TAG_T, TAG_A};
	endfunction

endpackage

>>> src/tlv_header_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_header_parser_unit
// Streaming tag-length-value header parser, one byte per item.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; the parse state updates as
//   the result is registered. One byte per cycle unless out_stall holds the
//   result register; the parse step is a single pass of logic.
// Reset: arst_n clears the parse state to idle, buffer_length to zero and
//   both pipeline stages to empty.
module tlv_header_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        start_req,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  value_byte,
	output logic        value_valid,
	output logic [7:0]  field_tag,
	output logic        field_end,
	output logic [31:0] iteration_count,
	output logic        iteration_valid
);
	import tlvhp_pkg::*;

	logic [31:0] buffer_length_q;
	parse_st_t   state_q;
	parse_st_t   state_nxt;
	parse_res_t  res_nxt;
	parse_res_t  res_s2;
	logic        valid_s1;
	logic        start_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= '0;
		end else if (cfg_we) begin
			buffer_length_q <= cfg_wdata;
		end
	end

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			start_s1 <= start_req;
			byte_s1  <= data_byte;
		end
	end

	tlvhp_step u_step (
		.cur           (state_q),
		.buffer_length (buffer_length_q),
		.start_req     (start_s1),
		.data_byte     (byte_s1),
		.nxt           (state_nxt),
		.res           (res_nxt)
	);

	// all-zero is idle phase with parsing status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign status          = res_s2.status;
	assign value_byte      = res_s2.value_byte;
	assign value_valid     = res_s2.value_valid;
	assign field_tag       = res_s2.field_tag;
	assign field_end       = res_s2.field_end;
	assign iteration_count = res_s2.iteration_count;
	assign iteration_valid = res_s2.iteration_valid;

`ifndef SYNTH
	a_ivalid_on_int_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && iteration_valid |-> value_valid && field_tag == TAG_I)
		else $error("iteration_valid without a tag i value byte");

	a_fend_on_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_end |-> value_valid)
		else $error("field_end on a non-value item");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled with nothing blocking");

	a_done_has_status: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_DONE |-> state_q.fstat != ST_PARSING)
		else $error("parser finished without a final status");

	a_idle_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_IDLE |-> state_q.fstat == ST_PARSING)
		else $error("idle parser holds a final status");
`endif

endmodule

>>> src/tlvhp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvhp_step
// Next-state and result logic for one header byte.
// ----------------------------------------------------------------------------
module tlvhp_step (
	input  tlvhp_pkg::parse_st_t  cur,
	input  logic [31:0]           buffer_length,
	input  logic                  start_req,
	input  logic [7:0]            data_byte,
	output tlvhp_pkg::parse_st_t  nxt,
	output tlvhp_pkg::parse_res_t res
);
	import tlvhp_pkg::*;

	parse_st_t   st;
	logic [23:0] len_full;
	logic [33:0] rec_end;
	logic [31:0] pos_inc;
	logic [23:0] len_dec;
	logic        vvalid;
	logic        fend;
	logic        ivalid;

	always_comb begin
		st = cur;
		if (start_req) begin
			st.pos   = '0;
			st.tag   = '0;
			st.len   = '0;
			st.acc   = '0;
			st.iseen = '0;
			st.fstat = ST_PARSING;
			st.phase = PH_TAG;
		end
	end

	assign len_full = {st.len[23:8], data_byte};
	// position after the value of this record, compared against the buffer
	assign rec_end  = {2'b00, st.pos} + 34'd1 + {10'd0, len_full};
	assign pos_inc  = st.pos + 32'd1;
	assign len_dec  = st.len - 24'd1;

	always_comb begin
		nxt    = st;
		vvalid = 1'b0;
		fend   = 1'b0;
		ivalid = 1'b0;
		if (st.phase != PH_IDLE && st.phase != PH_DONE) begin
			if (st.pos >= buffer_length) begin
				nxt.fstat = ST_ENDED;
				nxt.phase = PH_DONE;
			end else begin
				case (st.phase)
					PH_TAG: begin
						if (data_byte == TAG_END) begin
							nxt.tag   = TAG_END;
							nxt.fstat = ST_COMPLETE;
							nxt.phase = PH_DONE;
						end else if (!known_tag(data_byte)) begin
							nxt.tag   = data_byte;
							nxt.fstat = ST_UNKNOWN;
							nxt.phase = PH_DONE;
						end else begin
							nxt.tag   = data_byte;
							nxt.len   = '0;
							if (data_byte == TAG_I) begin
								nxt.acc   = '0;
								nxt.iseen = '0;
							end
							nxt.phase = PH_LEN_HI;
						end
					end
					PH_LEN_HI: begin
						nxt.len   = {data_byte, 16'd0};
						nxt.phase = PH_LEN_MID;
					end
					PH_LEN_MID: begin
						nxt.len   = {st.len[23:16], data_byte, 8'd0};
						nxt.phase = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						nxt.len = len_full;
						if (rec_end >= {2'b00, buffer_length}) begin
							nxt.fstat = ST_OVERRUN;
							nxt.phase = PH_DONE;
						end else if (st.tag == TAG_I && len_full < 24'(INT_BYTES)) begin
							nxt.fstat = ST_SHORT;
							nxt.phase = PH_DONE;
						end else if (len_full == 24'd0) begin
							nxt.phase = PH_TAG;
						end else begin
							nxt.phase = PH_VALUE;
						end
					end
					default: begin
						vvalid = 1'b1;
						if (st.tag == TAG_I && st.iseen < INT_BYTES) begin
							nxt.acc   = {st.acc[23:0], data_byte};
							nxt.iseen = st.iseen + 3'd1;
							ivalid    = (st.iseen == INT_BYTES - 3'd1);
						end
						nxt.len = len_dec;
						if (len_dec == 24'd0) begin
							fend      = 1'b1;
							nxt.phase = PH_TAG;
						end
					end
				endcase
				nxt.pos = pos_inc;
				if (nxt.phase != PH_DONE && pos_inc >= buffer_length) begin
					nxt.fstat = ST_ENDED;
					nxt.phase = PH_DONE;
				end
			end
		end
	end

	always_comb begin
		res.status          = nxt.fstat;
		res.value_byte      = vvalid ? data_byte : 8'd0;
		res.value_valid     = vvalid;
		res.field_tag       = nxt.tag;
		res.field_end       = fend;
		res.iteration_count = nxt.acc;
		res.iteration_valid = ivalid;
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte-stream test of tlv_header_parser_unit: buffers of TLV records, mostly
// well formed, some broken, are pushed through under several buffer lengths
// while both handshakes idle at random. Each result is checked field by field
// against a parse model kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
module testbench;

	import tlvhp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned MAX_PRINTS  = 40;
	localparam int unsigned PHASE_ITEMS = 36;

	typedef struct packed {
		logic       start;
		logic [7:0] data;
	} byte_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        start_req = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [7:0]  value_byte;
	logic        value_valid;
	logic [7:0]  field_tag;
	logic        field_end;
	logic [31:0] iteration_count;
	logic        iteration_valid;

	// stimulus and expectations
	byte_item_t  byte_q[$];
	parse_res_t  parse_results_q[$];
	logic        next_start = 1'b0;
	int unsigned queued_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	// handshake bookkeeping
	logic        in_fired = 1'b0;
	logic        out_fired = 1'b0;
	logic        item_held = 1'b0;
	logic        calm_in = 1'b0;
	logic        calm_out = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;

	// parse model state
	logic [31:0] buf_len = '0;
	logic [31:0] prs_pos = '0;
	phase_t      prs_phase = PH_IDLE;
	logic [7:0]  prs_tag = '0;
	logic [23:0] prs_len = '0;
	logic [31:0] prs_acc = '0;
	logic [2:0]  prs_iseen = '0;
	logic [2:0]  prs_fstat = ST_PARSING;

	tlv_header_parser_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.start_req       (start_req),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.value_byte      (value_byte),
		.value_valid     (value_valid),
		.field_tag       (field_tag),
		.field_end       (field_end),
		.iteration_count (iteration_count),
		.iteration_valid (iteration_valid)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic tag_known(input logic [7:0] t);
		case (t)
			TAG_K, TAG_S, TAG_D, TAG_I, TAG_M, TAG_N, TAG_T, TAG_A: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void end_parse(input logic [2:0] st);
		prs_fstat = st;
		prs_phase = PH_DONE;
	endfunction

	function automatic parse_res_t parse_byte(input logic start, input logic [7:0] b);
		parse_res_t r;
		logic [31:0] pos;
		r = '0;
		if (start) begin
			prs_pos = '0;
			prs_tag = '0;
			prs_len = '0;
			prs_acc = '0;
			prs_iseen = '0;
			prs_fstat = ST_PARSING;
			prs_phase = PH_TAG;
		end
		if (prs_phase != PH_IDLE && prs_phase != PH_DONE) begin
			pos = prs_pos;
			if (pos >= buf_len) begin
				end_parse(ST_ENDED);
			end else begin
				case (prs_phase)
					PH_TAG: begin
						prs_tag = b;
						if (b == TAG_END) begin
							end_parse(ST_COMPLETE);
						end else if (!tag_known(b)) begin
							end_parse(ST_UNKNOWN);
						end else begin
							prs_len = '0;
							if (b == TAG_I) begin
								prs_acc = '0;
								prs_iseen = '0;
							end
							prs_phase = PH_LEN_HI;
						end
					end
					PH_LEN_HI: begin
						prs_len = {b, 16'h0000};
						prs_phase = PH_LEN_MID;
					end
					PH_LEN_MID: begin
						prs_len = prs_len | {8'h00, b, 8'h00};
						prs_phase = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						prs_len = prs_len | {16'h0000, b};
						// at least one byte has to follow the value
						if ({1'b0, pos} + 33'd1 + {9'd0, prs_len} >= {1'b0, buf_len})
							end_parse(ST_OVERRUN);
						else if (prs_tag == TAG_I && prs_len < 24'(INT_BYTES))
							end_parse(ST_SHORT);
						else if (prs_len == '0)
							prs_phase = PH_TAG;
						else
							prs_phase = PH_VALUE;
					end
					PH_VALUE: begin
						r.value_byte = b;
						r.value_valid = 1'b1;
						if (prs_tag == TAG_I && prs_iseen < INT_BYTES) begin
							prs_acc = {prs_acc[23:0], b};
							prs_iseen = prs_iseen + 3'd1;
							if (prs_iseen == INT_BYTES)
								r.iteration_valid = 1'b1;
						end
						prs_len = prs_len - 24'd1;
						if (prs_len == '0) begin
							r.field_end = 1'b1;
							prs_phase = PH_TAG;
						end
					end
					default: ;
				endcase
				prs_pos = pos + 32'd1;
				if (prs_phase != PH_DONE && prs_pos >= buf_len)
					end_parse(ST_ENDED);
			end
		end
		r.status = prs_fstat;
		r.field_tag = prs_tag;
		r.iteration_count = prs_acc;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	task automatic check_result();
		parse_res_t e;
		if (parse_results_q.size() == 0) begin
			report_mismatch("result with no byte outstanding");
			return;
		end
		e = parse_results_q.pop_front();
		check_field("status", 32'(status), 32'(e.status));
		check_field("value_byte", 32'(value_byte), 32'(e.value_byte));
		check_field("value_valid", 32'(value_valid), 32'(e.value_valid));
		check_field("field_tag", 32'(field_tag), 32'(e.field_tag));
		check_field("field_end", 32'(field_end), 32'(e.field_end));
		check_field("iteration_count", iteration_count, e.iteration_count);
		check_field("iteration_valid", 32'(iteration_valid), 32'(e.iteration_valid));
	endtask

	// sample side: handshakes, config shadow, expectations and checks
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			in_fired = arst_n && in_valid && !in_stall;
			out_fired = arst_n && out_valid && !out_stall;
			if (arst_n && cfg_we)
				buf_len = cfg_wdata;
			if (in_fired)
				parse_results_q = {parse_results_q, parse_byte(start_req, data_byte)};
			if (out_fired)
				check_result();
		end
	end

	function automatic int unsigned draw_wait(input logic calm);
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	// byte driver
	always @(negedge clk) begin
		byte_item_t cur;
		if (arst_n) begin
			if (in_fired)
				item_held = 1'b0;
			if (!item_held) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (byte_q.size() > 0) begin
					cur = byte_q.pop_front();
					start_req <= cur.start;
					data_byte <= cur.data;
					in_valid <= 1'b1;
					item_held = 1'b1;
					if ($urandom_range(0, 39) == 0)
						calm_in = !calm_in;
					gap_left = draw_wait(calm_in);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fired) begin
				if ($urandom_range(0, 39) == 0)
					calm_out = !calm_out;
				stall_left = draw_wait(calm_out);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic put_byte(input logic [7:0] b);
		byte_item_t it;
		it.start = next_start;
		it.data = b;
		byte_q = {byte_q, it};
		next_start = 1'b0;
		queued_count++;
	endtask

	task automatic put_header(input logic [7:0] tg, input logic [23:0] len);
		put_byte(tg);
		put_byte(len[23:16]);
		put_byte(len[15:8]);
		put_byte(len[7:0]);
	endtask

	task automatic put_values(input int unsigned n);
		repeat (n) put_byte(8'($urandom));
	endtask

	function automatic logic [7:0] pick_tag();
		case ($urandom_range(0, 7))
			0: return TAG_K;
			1: return TAG_S;
			2: return TAG_D;
			3: return TAG_I;
			4: return TAG_M;
			5: return TAG_N;
			6: return TAG_T;
			default: return TAG_A;
		endcase
	endfunction

	function automatic logic [7:0] unknown_tag();
		logic [7:0] t;
		t = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
		while (t == TAG_END || tag_known(t))
			t = 8'($urandom);
		return t;
	endfunction

	// one buffer: well-formed records, then an end tag, an error or a cut; or only random bytes
	task automatic gen_buffer();
		longint unsigned pos, lim, len, room;
		int unsigned mode;
		logic [7:0] tg;
		lim = (buf_len <= 48) ? 64'(buf_len) : 64'($urandom_range(6, 48));
		mode = $urandom_range(0, 9);
		pos = 0;
		next_start = 1'b1;
		if (mode == 9) begin
			put_values($urandom_range(1, 10));
			return;
		end
		while (pos + 5 <= lim && $urandom_range(0, 5) != 0) begin
			room = lim - pos - 5;
			tg = pick_tag();
			if (tg == TAG_I && room < 4)
				tg = TAG_A;
			len = 64'($urandom_range((tg == TAG_I) ? 4 : 0, 32'((room > 9) ? 9 : room)));
			put_header(tg, len[23:0]);
			put_values(32'(len));
			pos += 4 + len;
		end
		case (mode)
			7: begin
				case ($urandom_range(0, 2))
					0: put_byte(unknown_tag());
					1: begin
						// overrun, sometimes exactly at the buffer end
						if (buf_len >= pos + 4 && buf_len - pos - 4 <= 64'hFF_FFFF &&
								$urandom_range(0, 1) == 1)
							len = buf_len - pos - 4;
						else
							len = 64'($urandom_range(0, 24'hFF_FFFF));
						put_header(pick_tag(), len[23:0]);
						put_values(2);
					end
					default: begin
						put_header(TAG_I, 24'($urandom_range(0, 3)));
						put_values(2);
					end
				endcase
			end
			8: begin
				put_byte(pick_tag());
				put_values($urandom_range(0, 4));
			end
			default: put_byte(TAG_END);
		endcase
		put_values($urandom_range(0, 2));
	endtask

	task automatic wait_idle();
		while (byte_q.size() > 0 || item_held || in_valid || parse_results_q.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_buffer_length(input logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [31:0] lens [0:8];
		int unsigned mark;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset length is zero: idle bytes ignored, first tag already past the end
		put_byte(8'hFF);
		next_start = 1'b1;
		put_byte(TAG_K);
		put_byte(TAG_END);
		wait_idle();

		write_buffer_length(32'd24);
		// long integer record with the largest count, zero-length record, end
		next_start = 1'b1;
		put_header(TAG_I, 24'd5);
		repeat (4) put_byte(8'hFF);
		put_byte(8'h00);
		put_header(TAG_K, 24'd0);
		put_byte(TAG_END);
		put_byte(8'h5A);
		next_start = 1'b1;
		put_byte(8'hFF);
		next_start = 1'b1;
		put_header(TAG_I, 24'd3);
		next_start = 1'b1;
		put_header(TAG_S, 24'hFF_FFFF);
		wait_idle();

		lens[0] = 32'd1;
		lens[1] = 32'hFFFF_FFFF;
		lens[2] = 32'd64;
		lens[3] = 32'd0;
		lens[4] = $urandom_range(5, 60);
		lens[5] = $urandom_range(5, 60);
		lens[6] = $urandom_range(5, 60);
		lens[7] = $urandom;
		lens[8] = 32'd2;
		for (int p = 0; p < 9; p++) begin
			write_buffer_length(lens[p]);
			mark = queued_count;
			while (queued_count - mark < PHASE_ITEMS) begin
				// stray bytes without a start either continue the buffer or are ignored
				if ($urandom_range(0, 7) == 0)
					put_values($urandom_range(1, 3));
				gen_buffer();
			end
			wait_idle();
		end

		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
